// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the stepper phase generator, sampled on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define SPG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// expression must never be true out of reset
`define SPG_ASSERT_NEVER(label, expr, msg) \
	`SPG_ASSERT(label, !(expr), msg)

`endif

// ===== rtl/spg_pkg.sv =====
// ----------------------------------------------------------------------------
// spg_pkg
// Shared types and constants of the stepper phase generator.
// ----------------------------------------------------------------------------
`default_nettype none

package spg_pkg;

	// speed command width default
	localparam int SPEED_WIDTH_DEF = 16;

	// configuration register widths
	localparam int MAX_SPEED_W  = 10;
	localparam int PERIOD_W     = 15;
	localparam int PS_WAIT_W    = 8;
	localparam int CFG_DATA_W   = 15;
	localparam int CFG_IDX_W    = 2;

	// state widths
	localparam int PHASE_W      = 2;
	localparam int COUNTDOWN_W  = 16;
	localparam int IDLE_W       = 8;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_SCALE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_DELAY    = 2'd2;

	// register reset values
	localparam logic [MAX_SPEED_W-1:0] MAX_SPEED_RST  = 10'd128;
	localparam logic [PERIOD_W-1:0]    PERIOD_RST     = 15'd1280;
	localparam logic [PS_WAIT_W-1:0]   PS_WAIT_RST    = 8'd15;

	// divider request and response
	typedef struct packed {
		logic                   start;
		logic [PERIOD_W-1:0]    dividend;
		logic [MAX_SPEED_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                busy;
		logic                done;
		logic [PERIOD_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/spg_cmd_if.sv =====
// ----------------------------------------------------------------------------
// spg_cmd_if
// Speed command channel: one transfer per control tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface spg_cmd_if #(
	parameter int SPEED_WIDTH = spg_pkg::SPEED_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SPEED_WIDTH-1:0] speed_cmd;

	modport source (output valid, output speed_cmd, input ready);
	modport sink   (input valid, input speed_cmd, output ready);
endinterface

`default_nettype wire

// ===== rtl/spg_phase_if.sv =====
// ----------------------------------------------------------------------------
// spg_phase_if
// Coil drive channel: one transfer per control tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface spg_phase_if;
	logic                        valid;
	logic                        ready;
	logic [spg_pkg::PHASE_W-1:0] coil_phase;
	logic                        coils_off;
	logic                        stepped;

	modport source (output valid, output coil_phase, output coils_off, output stepped,
		input ready);
	modport sink   (input valid, input coil_phase, input coils_off, input stepped,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/spg_div.sv =====
// ----------------------------------------------------------------------------
// spg_div
// Restoring serial divider, one quotient bit per cycle, for the step period.
// ----------------------------------------------------------------------------
`default_nettype none

module spg_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire spg_pkg::div_req_t req,
	output spg_pkg::div_rsp_t      rsp
);
	localparam int DVD_W = spg_pkg::PERIOD_W;
	localparam int DVS_W = spg_pkg::MAX_SPEED_W;
	localparam int REM_W = DVS_W + 1;
	localparam int CNT_W = $clog2(DVD_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [REM_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;

	logic [REM_W-1:0] trial;
	logic             fits;

	// shift in the next dividend bit and try the subtraction
	assign trial = {rem_q[REM_W-2:0], quo_q[DVD_W-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, dvs_q}) : trial;
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

// ===== rtl/stepper_phase_generator.sv =====
// ----------------------------------------------------------------------------
// stepper_phase_generator: full-step coil phase sequencer with power save
// a command transfer goes to CALC, then to DIV (the serial period divider) only for a
// tick that steps, then to EMIT, which waits until the result register is free
// throughput: one tick at a time, the next command is taken once the result is
// registered; arst_n clears phase, countdown, idle count, loads register defaults
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module stepper_phase_generator #(
	parameter int SPEED_WIDTH = spg_pkg::SPEED_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	spg_cmd_if.sink                                cmd,
	spg_phase_if.source                            phase,
	input  wire logic                              cfg_we,
	input  wire logic [spg_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [spg_pkg::CFG_DATA_W-1:0]    cfg_data
);
	localparam int EXT_W = ((SPEED_WIDTH > spg_pkg::MAX_SPEED_W) ?
		SPEED_WIDTH : spg_pkg::MAX_SPEED_W) + 1;
	localparam int MS_W  = spg_pkg::MAX_SPEED_W;
	localparam int CD_W  = spg_pkg::COUNTDOWN_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;

	logic [MS_W-1:0]                 max_speed_q;
	logic [spg_pkg::PERIOD_W-1:0]    period_q;
	logic [spg_pkg::PS_WAIT_W-1:0]   ps_wait_q;

	logic [spg_pkg::PHASE_W-1:0]     phase_q;
	logic [CD_W-1:0]                 countdown_q;
	logic [spg_pkg::IDLE_W-1:0]      idle_q;

	logic [SPEED_WIDTH-1:0]          speed_q;
	logic                            res_off_q;
	logic                            res_step_q;

	logic                            out_valid_q;
	logic [spg_pkg::PHASE_W-1:0]     out_phase_q;
	logic                            out_off_q;
	logic                            out_step_q;

	spg_pkg::div_req_t div_req;
	spg_pkg::div_rsp_t div_rsp;

	logic signed [EXT_W-1:0] s_ext;
	logic signed [EXT_W-1:0] lim_ext;
	logic signed [EXT_W-1:0] s_abs;
	logic                    s_neg;
	logic                    clamp;
	logic [MS_W-1:0]         mag;
	logic [CD_W-1:0]         cd_dec;
	logic                    do_step;
	logic                    emit_load;

	// clamp the command and take its magnitude
	assign s_ext   = EXT_W'(signed'(speed_q));
	assign lim_ext = signed'({{(EXT_W - MS_W){1'b0}}, max_speed_q});
	assign s_neg   = speed_q[SPEED_WIDTH-1];
	assign s_abs   = s_neg ? -s_ext : s_ext;
	assign clamp   = (s_ext > lim_ext) || (s_ext < -lim_ext);
	assign mag     = clamp ? max_speed_q : s_abs[MS_W-1:0];

	// countdown decrement wraps within its width
	assign cd_dec  = countdown_q - 1'b1;
	assign do_step = cd_dec[CD_W-1] || (cd_dec == '0);

	// period divider
	assign div_req.start    = (state_q == ST_CALC) && (mag != '0) && do_step;
	assign div_req.dividend = period_q;
	assign div_req.divisor  = mag;

	spg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= spg_pkg::MAX_SPEED_RST;
			period_q    <= spg_pkg::PERIOD_RST;
			ps_wait_q   <= spg_pkg::PS_WAIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				spg_pkg::CFG_MAX_SPEED:    max_speed_q <= cfg_data[MS_W-1:0];
				spg_pkg::CFG_PERIOD_SCALE: period_q    <= cfg_data[spg_pkg::PERIOD_W-1:0];
				spg_pkg::CFG_OFF_DELAY:    ps_wait_q   <= cfg_data[spg_pkg::PS_WAIT_W-1:0];
				default: ;
			endcase
		end
	end

	// the result register takes the pending result when free
	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || phase.ready);

	// sequencer and motor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= '0;
			countdown_q <= '0;
			idle_q      <= '0;
			res_off_q   <= 1'b0;
			res_step_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.valid) state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (mag == '0) begin
						res_off_q  <= 1'b1;
						res_step_q <= 1'b0;
						state_q    <= ST_EMIT;
					end else if (do_step) begin
						phase_q    <= s_neg ? (phase_q - 1'b1) : (phase_q + 1'b1);
						idle_q     <= '0;
						res_off_q  <= 1'b0;
						res_step_q <= 1'b1;
						state_q    <= ST_DIV;
					end else begin
						countdown_q <= cd_dec;
						res_step_q  <= 1'b0;
						if (idle_q >= ps_wait_q) begin
							res_off_q <= 1'b1;
						end else begin
							idle_q    <= idle_q + 1'b1;
							res_off_q <= 1'b0;
						end
						state_q <= ST_EMIT;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						countdown_q <= CD_W'(div_rsp.quotient);
						state_q     <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// command capture
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) speed_q <= cmd.speed_cmd;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (phase.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_phase_q <= phase_q;
			out_off_q   <= res_off_q;
			out_step_q  <= res_step_q;
		end
	end

	assign cmd.ready        = (state_q == ST_IDLE);
	assign phase.valid      = out_valid_q;
	assign phase.coil_phase = out_phase_q;
	assign phase.coils_off  = out_off_q;
	assign phase.stepped    = out_step_q;

	// checks
	`SPG_ASSERT(a_div_busy_in_div, div_rsp.busy |-> (state_q == ST_DIV), "divider busy early")
	`SPG_ASSERT(a_div_done_in_div, div_rsp.done |-> (state_q == ST_DIV), "divider done early")
	`SPG_ASSERT_NEVER(a_step_powered, phase.valid && phase.coils_off && phase.stepped, "step off")

endmodule

`default_nettype wire
